[design/button_press_repeat_tracker_top_assert.svh]
// Assertion macros for the button press repeat tracker.
// Included by the top level; depends on nothing else.
`ifndef BUTTON_PRESS_REPEAT_TRACKER_TOP_ASSERT_SVH
`define BUTTON_PRESS_REPEAT_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on aclk while reset is released.
`define BPRT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("button tracker assertion failed");

// Checked on aclk also during reset.
`define BPRT_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("button tracker reset assertion failed");

`else

`define BPRT_ASSERT(lbl, prop)
`define BPRT_ASSERT_RST(lbl, prop)

`endif

`endif

[design/bprt_pkg.sv]
// Package for the button press repeat tracker: sizes, codes and helpers.
// Used by button_press_repeat_tracker_top; depends on nothing.
package bprt_pkg;

    // Number of tracked buttons and width of the visible masks.
    localparam int BUTTONS    = 20;
    localparam int OUT_W      = 20;
    localparam int ID_W       = 5;
    localparam int TICK_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int IDX_W      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int WIDE_W     = (BUTTONS > OUT_W) ? BUTTONS : OUT_W;

    // Item kinds.
    localparam logic [1:0] FN_TICK   = 2'd0;
    localparam logic [1:0] FN_BUTTON = 2'd1;
    localparam logic [1:0] FN_HAT    = 2'd2;

    // Hat axis code for the positive side.
    localparam logic [1:0] HAT_POS = 2'b01;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 1'd1;

    typedef logic [BUTTONS-1:0] btn_mask_t;
    typedef logic [OUT_W-1:0]   out_mask_t;

    // Cut or pad a button mask to the visible output width.
    function automatic out_mask_t visible(btn_mask_t m);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(m);
        return t[OUT_W-1:0];
    endfunction

endpackage

[design/button_press_repeat_tracker_top.sv]
// Button press repeat tracker: held, edge and auto-repeat masks.
// Depends on bprt_pkg and button_press_repeat_tracker_top_assert.svh.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  func, button_id, second_id, pressed, hat_value, tick
//  m_       out        m_valid / m_ready  held, pressed edge, released edge, repeat masks
//  cfg_     in         cfg_we             cfg_addr, cfg_wdata
//
// A frame tick runs a scan: one shared 32-bit adder and comparator walk the
// repeat times one button per cycle. A button event passes one side step and a
// hat event two, one per side through the same adder. Unused codes skip to the final step.
// s_ready is high only in the idle state; a finished result waits in the output
// register while the next request is accepted and worked on, and that request
// holds in its final step until the output register is free.
// Reset is synchronous and active low; the repeat times have no reset.
module button_press_repeat_tracker_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bprt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bprt_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_func,
    input  logic [bprt_pkg::ID_W-1:0]          s_button_id,
    input  logic [bprt_pkg::ID_W-1:0]          s_second_id,
    input  logic                               s_pressed,
    input  logic signed [1:0]                  s_hat_value,
    input  logic [bprt_pkg::TICK_W-1:0]        s_tick,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bprt_pkg::OUT_W-1:0]         m_held_mask,
    output logic [bprt_pkg::OUT_W-1:0]         m_pressed_edge_mask,
    output logic [bprt_pkg::OUT_W-1:0]         m_released_edge_mask,
    output logic [bprt_pkg::OUT_W-1:0]         m_repeat_mask
);
    import bprt_pkg::*;

    `include "button_press_repeat_tracker_top_assert.svh"

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SIDE_A = 3'd2;
    localparam logic [2:0] S_SIDE_B = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    logic [CFG_W-1:0]  delay_reg, interval_reg;

    btn_mask_t         held_reg, held_next;
    btn_mask_t         pedge_reg, pedge_next;
    btn_mask_t         redge_reg, redge_next;
    btn_mask_t         rpt_reg, rpt_next;
    logic [TICK_W-1:0] due_reg [BUTTONS];

    // Latched request.
    logic [1:0]        func_reg;
    logic [ID_W-1:0]   id_a_reg, id_b_reg;
    logic              press_reg;
    logic [1:0]        hat_reg;
    logic [TICK_W-1:0] tick_reg;

    logic              m_valid_reg;
    out_mask_t         m_held_reg, m_pedge_reg, m_redge_reg, m_rpt_reg;

    // Shared unit operands and results.
    logic [TICK_W-1:0] add_a, add_b, add_sum, due_rd;
    logic              due_hit;

    // Side handling for button and hat events.
    logic [ID_W-1:0]   side_id;
    logic              side_down, side_valid;
    logic [IDX_W-1:0]  side_idx;
    btn_mask_t         side_bit, scan_bit;

    logic              s_fire, out_free;
    logic              due_we;
    logic [IDX_W-1:0]  due_waddr;

    assign s_fire   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Operand select for the one adder and comparator.
    assign due_rd  = due_reg[cnt_reg];
    assign add_a   = (state_reg == S_SCAN) ? due_rd : tick_reg;
    assign add_b   = (state_reg == S_SCAN) ? TICK_W'(interval_reg) : TICK_W'(delay_reg);
    assign add_sum = add_a + add_b;
    assign due_hit = (tick_reg >= due_rd);

    // Which button the current event side addresses, and the direction.
    always_comb begin
        side_id   = (state_reg == S_SIDE_B) ? id_b_reg : id_a_reg;
        if (state_reg == S_SIDE_B) begin
            side_down = (hat_reg == HAT_POS);
        end else if (func_reg == FN_HAT) begin
            side_down = hat_reg[1];
        end else begin
            side_down = press_reg;
        end
        side_valid = ({1'b0, side_id} < (ID_W + 1)'(BUTTONS));
        side_idx   = side_id[IDX_W-1:0];
        side_bit   = side_valid ? (btn_mask_t'(1) << side_idx) : '0;
        scan_bit   = btn_mask_t'(1) << cnt_reg;
    end

    // Sequencer and mask update.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        pedge_next = pedge_reg;
        redge_next = redge_reg;
        rpt_next   = rpt_reg;
        due_we     = 1'b0;
        due_waddr  = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    cnt_next = '0;
                    priority if (s_func == FN_TICK) begin
                        pedge_next = '0;
                        redge_next = '0;
                        rpt_next   = '0;
                        state_next = S_SCAN;
                    end else if (s_func == FN_BUTTON || s_func == FN_HAT) begin
                        state_next = S_SIDE_A;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (((held_reg & scan_bit) != '0) && due_hit) begin
                    rpt_next = rpt_reg | scan_bit;
                    due_we   = 1'b1;
                end
                if (cnt_reg == IDX_W'(BUTTONS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SIDE_A, S_SIDE_B: begin
                if (side_valid) begin
                    if (!side_down) begin
                        if ((held_reg & side_bit) != '0) begin
                            held_next  = held_reg & ~side_bit;
                            rpt_next   = rpt_reg & ~side_bit;
                            redge_next = redge_reg | side_bit;
                        end
                    end else if ((held_reg & side_bit) == '0) begin
                        held_next  = held_reg | side_bit;
                        pedge_next = pedge_reg | side_bit;
                        rpt_next   = rpt_reg | side_bit;
                        due_we     = 1'b1;
                        due_waddr  = side_idx;
                    end
                end
                if (state_reg == S_SIDE_A && func_reg == FN_HAT) begin
                    state_next = S_SIDE_B;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and masks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            held_reg     <= '0;
            pedge_reg    <= '0;
            redge_reg    <= '0;
            rpt_reg      <= '0;
            delay_reg    <= CFG_W'(300);
            interval_reg <= CFG_W'(100);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
            pedge_reg <= pedge_next;
            redge_reg <= redge_next;
            rpt_reg   <= rpt_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_DELAY:    delay_reg    <= cfg_wdata;
                    REG_INTERVAL: interval_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request latch, repeat times and output payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg  <= s_func;
            id_a_reg  <= s_button_id;
            id_b_reg  <= s_second_id;
            press_reg <= s_pressed;
            hat_reg   <= s_hat_value;
            tick_reg  <= s_tick;
        end
        if (due_we) begin
            due_reg[due_waddr] <= add_sum;
        end
        if (state_reg == S_DONE && out_free) begin
            m_held_reg  <= visible(held_reg);
            m_pedge_reg <= visible(pedge_reg);
            m_redge_reg <= visible(redge_reg);
            m_rpt_reg   <= visible(rpt_reg);
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_held_mask          = m_held_reg;
    assign m_pressed_edge_mask  = m_pedge_reg;
    assign m_released_edge_mask = m_redge_reg;
    assign m_repeat_mask        = m_rpt_reg;

    // The scan counter never leaves the button range.
    `BPRT_ASSERT(a_scan_range, (state_reg == S_SCAN) |-> (cnt_reg <= IDX_W'(BUTTONS - 1)))

    // A repeating button is always a held one.
    `BPRT_ASSERT(a_rpt_held, (rpt_reg & ~held_reg) == '0)

    // A frame tick clears the edge masks and starts the scan.
    `BPRT_ASSERT(a_tick_clear, (s_fire && s_func == FN_TICK) |=>
        (state_reg == S_SCAN && pedge_reg == '0 && redge_reg == '0))

    // Reset leaves the sequencer idle with no pending result.
    `BPRT_ASSERT_RST(a_reset, !aresetn |=> (state_reg == S_IDLE && !m_valid_reg))

endmodule
